// ===== rtl/core/qam_bit_to_symbol_mapper_assert.svh =====
// assertion helpers for the bit-to-symbol mapper
`ifndef QAM_BIT_TO_SYMBOL_MAPPER_ASSERT_SVH
`define QAM_BIT_TO_SYMBOL_MAPPER_ASSERT_SVH

// condition must hold in the same cycle
`define QBSM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// condition must hold in the next cycle
`define QBSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/qbsm_pkg.sv =====
package qbsm_pkg;

    localparam int MAX_BITS_PER_SYMBOL = 8;
    localparam int QAM64_BITS          = 6;
    localparam logic [7:0] QAM64_MASK  = 8'h3f;
    localparam int SYM_W               = 8;
    localparam int LEFT_W              = 6;
    localparam int ACC_W               = LEFT_W + 8;
    localparam int AMP_W               = 5;

    typedef enum logic {
        MODE_QAM64  = 1'b0,
        MODE_QAM256 = 1'b1
    } t_mode;

    typedef struct packed {
        logic signed [AMP_W-1:0] i_amp;
        logic signed [AMP_W-1:0] q_amp;
        logic                    end_of_run;
    } t_result;

    typedef struct packed {
        t_result           res0;
        t_result           res1;
        logic [1:0]        num;
        logic [LEFT_W-1:0] left_bits;
        logic [2:0]        left_cnt;
    } t_slice;

    // gray level from one bit lane: r = bit ? r - 2^j : 2^j - r
    function automatic logic signed [AMP_W-1:0] amp_level(
        input logic [SYM_W-1:0] sym,
        input logic [2:0]       pairs,
        input logic             sel
    );
        logic signed [AMP_W:0] r;
        logic signed [AMP_W:0] stp;
        r = '0;
        for (int j = 0; j < SYM_W / 2; j++) begin
            stp = (AMP_W + 1)'(1 << j);
            if (3'(j) < pairs) begin
                if (sym[2 * j + int'(sel)]) begin
                    r = r - stp;
                end else begin
                    r = stp - r;
                end
            end
        end
        return r[AMP_W-1:0];
    endfunction

endpackage

// ===== rtl/core/qbsm_slicer.sv =====
module qbsm_slicer #(
    parameter int P_MAX_BITS = qbsm_pkg::MAX_BITS_PER_SYMBOL
) (
    input  qbsm_pkg::t_mode                   i_mode,
    input  logic [qbsm_pkg::LEFT_W-1:0]       i_left_bits,
    input  logic [2:0]                        i_left_cnt,
    input  logic [7:0]                        i_byte,
    input  logic                              i_last,
    output qbsm_pkg::t_slice                  o_slice
);

    localparam logic [qbsm_pkg::SYM_W-1:0] FULL_MASK =
        qbsm_pkg::SYM_W'((1 << P_MAX_BITS) - 1);

    logic [3:0]                     bits;
    logic [2:0]                     pairs;
    logic [qbsm_pkg::SYM_W-1:0]     sym_mask;
    logic [qbsm_pkg::LEFT_W-1:0]    lmask;
    logic [qbsm_pkg::ACC_W-1:0]     acc;
    logic [qbsm_pkg::ACC_W-1:0]     rmask;
    logic [3:0]                     cnt0;
    logic [3:0]                     rem1;
    logic [3:0]                     rem2;
    logic [3:0]                     rem;
    logic                           have1;
    logic                           have2;
    logic [qbsm_pkg::SYM_W-1:0]     sym0;
    logic [qbsm_pkg::SYM_W-1:0]     sym1;

    always_comb begin
        bits     = (i_mode == qbsm_pkg::MODE_QAM256) ? 4'(P_MAX_BITS) : 4'(qbsm_pkg::QAM64_BITS);
        pairs    = bits[3:1];
        sym_mask = (i_mode == qbsm_pkg::MODE_QAM256) ? FULL_MASK : qbsm_pkg::QAM64_MASK;

        // only the low left_cnt leftover bits count
        lmask = qbsm_pkg::LEFT_W'((7'd1 << i_left_cnt) - 7'd1);
        acc   = {i_left_bits & lmask, i_byte};
        cnt0  = {1'b0, i_left_cnt} + 4'd8;

        have1 = (cnt0 >= bits);
        rem1  = cnt0 - bits;
        have2 = have1 && (rem1 >= bits);
        rem2  = rem1 - bits;
        rem   = have2 ? rem2 : (have1 ? rem1 : cnt0);

        sym0 = qbsm_pkg::SYM_W'(acc >> rem1) & sym_mask;
        sym1 = qbsm_pkg::SYM_W'(acc >> rem2) & sym_mask;

        o_slice.res0.i_amp      = qbsm_pkg::amp_level(sym0, pairs, 1'b1);
        o_slice.res0.q_amp      = qbsm_pkg::amp_level(sym0, pairs, 1'b0);
        o_slice.res0.end_of_run = !have2;
        o_slice.res1.i_amp      = qbsm_pkg::amp_level(sym1, pairs, 1'b1);
        o_slice.res1.q_amp      = qbsm_pkg::amp_level(sym1, pairs, 1'b0);
        o_slice.res1.end_of_run = 1'b1;
        o_slice.num             = have2 ? 2'd2 : (have1 ? 2'd1 : 2'd0);

        rmask = qbsm_pkg::ACC_W'((15'd1 << rem) - 15'd1);
        if (i_last || rem > 4'd6) begin
            o_slice.left_bits = '0;
            o_slice.left_cnt  = '0;
        end else begin
            o_slice.left_bits = qbsm_pkg::LEFT_W'(acc & rmask);
            o_slice.left_cnt  = rem[2:0];
        end
    end

endmodule

// ===== rtl/core/qam_bit_to_symbol_mapper.sv =====
// qam bit-to-symbol mapper
// slave stream: one byte of packed bits per request, first bit in tdata[7];
//   tlast drops the bits left over after that byte
// master stream: one i/q point per request, tlast on the last point a byte made
// config channel: one-bit mode write (0 = qam64, 6 bits; 1 = qam256,
//   MAX_BITS_PER_SYMBOL bits); always ready, write only while the block is idle
// a byte is sliced and mapped in the cycle it is taken; its points land in a
//   three-entry result queue, whose head register drives the master side
// a byte is taken whenever the queue holds at most one point; a byte that makes
//   two points therefore holds off the next byte until the single-wide result
//   port has drained a point from the queue
// reset clears the queue and the leftover bits and selects qam256
// a stalled master side fills the queue past one point and then drops the slave tready; held
//   points stay stable and none is lost
module qam_bit_to_symbol_mapper #(
    parameter int MAX_BITS_PER_SYMBOL = qbsm_pkg::MAX_BITS_PER_SYMBOL
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,         // mode
    // byte stream in
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,     // data_byte
    input  logic        i_s_axis_tlast,     // last_byte
    // symbol stream out
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,     // [4:0] i_amp, [9:5] q_amp, zero pad
    output logic        o_m_axis_tlast      // end_of_run
);

    // mode and leftover bit state
    qbsm_pkg::t_mode                r_mode;
    logic [qbsm_pkg::LEFT_W-1:0]    r_left_bits;
    logic [2:0]                     r_left_cnt;

    // result queue, head at entry 0
    qbsm_pkg::t_result              r_buf [0:2];
    qbsm_pkg::t_result              n_buf [0:2];
    logic [1:0]                     r_cnt;
    logic [1:0]                     n_cnt;
    logic [1:0]                     base;

    qbsm_pkg::t_slice               slice;
    logic                           in_fire;
    logic                           out_fire;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_cnt <= 2'd1);
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_fire        = o_m_axis_tvalid && i_m_axis_tready;

    assign o_m_axis_tvalid = (r_cnt != 2'd0);
    assign o_m_axis_tdata  = {6'd0, r_buf[0].q_amp, r_buf[0].i_amp};
    assign o_m_axis_tlast  = r_buf[0].end_of_run;

    // slice the byte into symbols and map them
    qbsm_slicer #(
        .P_MAX_BITS (MAX_BITS_PER_SYMBOL)
    ) u_slicer (
        .i_mode      (r_mode),
        .i_left_bits (r_left_bits),
        .i_left_cnt  (r_left_cnt),
        .i_byte      (i_s_axis_tdata),
        .i_last      (i_s_axis_tlast),
        .o_slice     (slice)
    );

    // queue update: pop the head, then append the new points behind the rest
    always_comb begin
        n_buf = r_buf;
        if (out_fire) begin
            n_buf[0] = r_buf[1];
            n_buf[1] = r_buf[2];
        end
        base  = r_cnt - {1'b0, out_fire};
        n_cnt = base;
        if (in_fire) begin
            if (slice.num != 2'd0) begin
                n_buf[base] = slice.res0;
            end
            if (slice.num == 2'd2) begin
                n_buf[base + 2'd1] = slice.res1;
            end
            n_cnt = base + slice.num;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= qbsm_pkg::MODE_QAM256;
            r_left_bits <= '0;
            r_left_cnt  <= '0;
            r_cnt       <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= qbsm_pkg::t_mode'(i_cfg_data);
            end
            if (in_fire) begin
                r_left_bits <= slice.left_bits;
                r_left_cnt  <= slice.left_cnt;
            end
            r_cnt <= n_cnt;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
    end

    `include "qam_bit_to_symbol_mapper_assert.svh"

    `QBSM_ASSERT_NOW(a_left_cnt_range, 1'b1, r_left_cnt <= 3'd6, "leftover count above six")
    `QBSM_ASSERT_NEXT(a_last_clears, in_fire && i_s_axis_tlast, r_left_cnt == 3'd0, "leftover kept after last byte")
    `QBSM_ASSERT_NEXT(a_pop_count, !in_fire && out_fire, r_cnt == $past(r_cnt) - 2'd1, "queue count off after pop")

endmodule
